/* src/rc4_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

  localparam int SBOX_SIZE = 256;
  localparam int SBOX_AW = 8;
  localparam int BYTE_W = 8;
  localparam int KEY_LEN_W = 9;
  localparam int KEY_DEPTH_DEF = 256;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 9'd16;

  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_DATA = 1'b1;

endpackage

`default_nettype wire

/* src/rc4_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rc4_ram #(
  parameter int DEPTH = rc4_pkg::SBOX_SIZE,
  parameter int AW = rc4_pkg::SBOX_AW
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [rc4_pkg::BYTE_W-1:0]  wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [rc4_pkg::BYTE_W-1:0]  rdata
);

  logic [rc4_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read is always live, data registered and shown the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/rc4_stream_cipher.sv */
`timescale 1ns / 1ps
`default_nettype none
// Key write: taken while idle, the block stays ready. Data byte: P_RD, P_J, P_W1, P_W2,
// P_T, P_OUT; result registered in P_OUT once the output is free, no beat taken meanwhile;
// the first byte of a message first runs the key schedule: fill, then per entry K_RD,
// K_J, K_W1, K_W2. All sbox traffic goes through one RAM with one read and one write port.
// Reset (rst, synchronous): sequencer idle, indices zero, schedule pending, key_length 16.

module rc4_stream_cipher #(
  parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rc4_pkg::KEY_LEN_W-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           mode,
  input  wire logic [rc4_pkg::BYTE_W-1:0]     data_byte,
  input  wire logic [rc4_pkg::BYTE_W-1:0]     key_index,
  input  wire logic                           message_last,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [rc4_pkg::BYTE_W-1:0]     out_byte,
  output logic      [rc4_pkg::BYTE_W-1:0]     keystream_byte,
  output logic                                result_last
);

  localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW = rc4_pkg::KEY_LEN_W;
  localparam int BW = rc4_pkg::BYTE_W;
  localparam logic [LW-1:0] KEY_DEPTH_L = LW'(KEY_DEPTH);
  localparam logic [BW-1:0] LAST_N = BW'(rc4_pkg::SBOX_SIZE - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INIT  = 4'd1;
  localparam logic [3:0] ST_K_RD  = 4'd2;
  localparam logic [3:0] ST_K_J   = 4'd3;
  localparam logic [3:0] ST_K_W1  = 4'd4;
  localparam logic [3:0] ST_K_W2  = 4'd5;
  localparam logic [3:0] ST_P_RD  = 4'd6;
  localparam logic [3:0] ST_P_J   = 4'd7;
  localparam logic [3:0] ST_P_W1  = 4'd8;
  localparam logic [3:0] ST_P_W2  = 4'd9;
  localparam logic [3:0] ST_P_T   = 4'd10;
  localparam logic [3:0] ST_P_OUT = 4'd11;

  logic [3:0]        state;
  logic [LW-1:0]     key_length;
  logic              sched_needed;
  logic [BW-1:0]     n;
  logic [KEY_AW-1:0] kpos;
  logic [BW-1:0]     idx_i;
  logic [BW-1:0]     idx_j;
  logic [BW-1:0]     si;
  logic [BW-1:0]     sj;
  logic [BW-1:0]     data_q;
  logic              last_q;

  logic              s_we;
  logic [BW-1:0]     s_waddr;
  logic [BW-1:0]     s_wdata;
  logic [BW-1:0]     s_raddr;
  logic [BW-1:0]     s_rdata;
  logic              k_we;
  logic [BW-1:0]     k_rdata;

  logic              accept;
  logic              out_free;
  logic [LW-1:0]     eff_len;
  logic [LW-1:0]     kpos_inc;
  logic [BW-1:0]     j_sched;
  logic [BW-1:0]     j_prga;
  logic [BW-1:0]     i_inc;
  logic [BW-1:0]     t_addr;

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // zero length acts as one, anything past the store saturates
  always_comb begin
    if (key_length == '0) begin
      eff_len = LW'(1);
    end else if (key_length > KEY_DEPTH_L) begin
      eff_len = KEY_DEPTH_L;
    end else begin
      eff_len = key_length;
    end
  end

  assign kpos_inc = LW'(kpos) + LW'(1);
  assign j_sched = idx_j + s_rdata + k_rdata;
  assign j_prga = idx_j + s_rdata;
  assign i_inc = idx_i + BW'(1);
  // the swap leaves the sum of the two entries unchanged
  assign t_addr = si + sj;

  assign k_we = accept && (mode == rc4_pkg::MODE_KEY)
                && ({1'b0, key_index} < KEY_DEPTH_L);

  always_comb begin
    s_we = 1'b0;
    s_waddr = n;
    s_wdata = n;
    s_raddr = idx_i;
    unique case (state)
      ST_IDLE: begin
      end
      ST_INIT: begin
        s_we = 1'b1;
      end
      ST_K_RD: begin
        s_raddr = n;
      end
      ST_K_J: begin
        s_raddr = j_sched;
      end
      ST_K_W1: begin
        s_we = 1'b1;
        s_wdata = s_rdata;
      end
      ST_K_W2: begin
        s_we = 1'b1;
        s_waddr = idx_j;
        s_wdata = si;
      end
      ST_P_RD: begin
        s_raddr = i_inc;
      end
      ST_P_J: begin
        s_raddr = j_prga;
      end
      ST_P_W1: begin
        s_we = 1'b1;
        s_waddr = idx_i;
        s_wdata = s_rdata;
      end
      ST_P_W2: begin
        s_we = 1'b1;
        s_waddr = idx_j;
        s_wdata = si;
      end
      ST_P_T, ST_P_OUT: begin
        s_raddr = t_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= rc4_pkg::KEY_LEN_RST;
    end else if (cfg_we) begin
      key_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sched_needed <= 1'b1;
      idx_i <= '0;
      idx_j <= '0;
      out_valid <= 1'b0;
    end else begin
      // in ST_P_OUT the output register is handled below
      if (out_valid && !out_stall && (state != ST_P_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (mode == rc4_pkg::MODE_DATA)) begin
            data_q <= data_byte;
            last_q <= message_last;
            n <= '0;
            state <= sched_needed ? ST_INIT : ST_P_RD;
          end
        end
        ST_INIT: begin
          n <= n + BW'(1);
          if (n == LAST_N) begin
            idx_j <= '0;
            kpos <= '0;
            state <= ST_K_RD;
          end
        end
        ST_K_RD: begin
          state <= ST_K_J;
        end
        ST_K_J: begin
          si <= s_rdata;
          idx_j <= j_sched;
          state <= ST_K_W1;
        end
        ST_K_W1: begin
          state <= ST_K_W2;
        end
        ST_K_W2: begin
          n <= n + BW'(1);
          kpos <= (kpos_inc >= eff_len) ? '0 : kpos_inc[KEY_AW-1:0];
          if (n == LAST_N) begin
            idx_i <= '0;
            idx_j <= '0;
            sched_needed <= 1'b0;
            state <= ST_P_RD;
          end else begin
            state <= ST_K_RD;
          end
        end
        ST_P_RD: begin
          idx_i <= i_inc;
          state <= ST_P_J;
        end
        ST_P_J: begin
          si <= s_rdata;
          idx_j <= j_prga;
          state <= ST_P_W1;
        end
        ST_P_W1: begin
          sj <= s_rdata;
          state <= ST_P_W2;
        end
        ST_P_W2: begin
          state <= ST_P_T;
        end
        ST_P_T: begin
          state <= ST_P_OUT;
        end
        ST_P_OUT: begin
          // hold here while the previous result is still stalled
          if (out_free) begin
            out_valid <= 1'b1;
            out_byte <= data_q ^ s_rdata;
            keystream_byte <= s_rdata;
            result_last <= last_q;
            if (last_q) begin
              sched_needed <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  rc4_ram #(
    .DEPTH(rc4_pkg::SBOX_SIZE),
    .AW(rc4_pkg::SBOX_AW)
  ) u_sbox (
    .clk(clk),
    .we(s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  rc4_ram #(
    .DEPTH(KEY_DEPTH),
    .AW(KEY_AW)
  ) u_key (
    .clk(clk),
    .we(k_we),
    .waddr(key_index[KEY_AW-1:0]),
    .wdata(data_byte),
    .raddr(kpos),
    .rdata(k_rdata)
  );

endmodule

`default_nettype wire

/* src/rc4_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module rc4_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        mode,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [rc4_pkg::BYTE_W-1:0]  out_byte,
  input wire logic [rc4_pkg::BYTE_W-1:0]  keystream_byte,
  input wire logic                        result_last
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a data beat keeps the sequencer busy on the next cycle
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == rc4_pkg::MODE_DATA) |=> in_stall)
    else $error("ready straight after a data beat");

  // a key write completes in its own cycle
  a_key_quick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode == rc4_pkg::MODE_KEY) |=> !in_stall)
    else $error("key write left the block busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte)
      && $stable(keystream_byte) && $stable(result_last)))
    else $error("stalled result changed");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .mode(mode),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_byte(out_byte),
  .keystream_byte(keystream_byte),
  .result_last(result_last)
);

`default_nettype wire

/* sim/rc4_stream_cipher_test.sv */
`timescale 1ns / 1ps

module rc4_stream_cipher_test;

  localparam int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF;
  localparam int TOTAL_ITEMS = 1750;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 3000;

  typedef logic [rc4_pkg::BYTE_W-1:0] byte_t;
  typedef struct packed {
    byte_t cipher;
    byte_t stream;
    logic  last;
  } cipher_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rc4_pkg::KEY_LEN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = rc4_pkg::MODE_KEY;
  byte_t data_byte = '0;
  byte_t key_index = '0;
  logic message_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  byte_t out_byte;
  byte_t keystream_byte;
  logic result_last;

  // cipher state as the block should hold it
  byte_t perm [rc4_pkg::SBOX_SIZE];
  byte_t key_mem [KEY_DEPTH];
  bit key_set [KEY_DEPTH];
  byte_t idx_i, idx_j;
  bit rekey_pending;
  logic [rc4_pkg::KEY_LEN_W-1:0] key_len;
  cipher_beat_t cipher_q [$];

  int items_sent = 0;
  int errors = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;

  rc4_stream_cipher uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .data_byte(data_byte),
    .key_index(key_index),
    .message_last(message_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .keystream_byte(keystream_byte),
    .result_last(result_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int used_key_len();
    int len;
    len = key_len;
    if (len == 0) len = 1;
    if (len > KEY_DEPTH) len = KEY_DEPTH;
    return len;
  endfunction

  function automatic void swap_perm(int a, int b);
    byte_t tmp;
    tmp = perm[a];
    perm[a] = perm[b];
    perm[b] = tmp;
  endfunction

  function automatic void rekey();
    int len;
    int j;
    int kp;
    len = used_key_len();
    j = 0;
    kp = 0;
    for (int n = 0; n < rc4_pkg::SBOX_SIZE; n++) perm[n] = byte_t'(n);
    for (int n = 0; n < rc4_pkg::SBOX_SIZE; n++) begin
      j = (j + perm[n] + key_mem[kp]) & 255;
      swap_perm(n, j);
      kp++;
      if (kp >= len) kp = 0;
    end
    idx_i = '0;
    idx_j = '0;
    rekey_pending = 1'b0;
  endfunction

  function automatic void cipher_step(logic m, byte_t d, byte_t k, logic l);
    byte_t t;
    byte_t ks;
    cipher_beat_t beat;
    if (m == rc4_pkg::MODE_KEY) begin
      if (int'(k) < KEY_DEPTH) begin
        key_mem[k] = d;
        key_set[k] = 1'b1;
      end
      return;
    end
    if (rekey_pending) rekey();
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    swap_perm(idx_i, idx_j);
    t = perm[idx_i] + perm[idx_j];
    ks = perm[t];
    beat.cipher = d ^ ks;
    beat.stream = ks;
    beat.last = l;
    cipher_q.insert(cipher_q.size(), beat);
    if (l) rekey_pending = 1'b1;
  endfunction

  // mostly short, a few long
  function automatic int pick_gap(bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_beat(logic m, byte_t d, byte_t k, logic l);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    data_byte <= d;
    key_index <= k;
    message_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cipher_step(m, d, k, l);
    items_sent++;
    gap = pick_gap(send_gaps);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    // a trailing key write leaves no result behind
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_length(int v);
    wait_for_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[rc4_pkg::KEY_LEN_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    key_len = v[rc4_pkg::KEY_LEN_W-1:0];
  endtask

  // the schedule must never read a key byte that was not written
  task automatic load_missing_keys();
    int len;
    len = used_key_len();
    for (int n = 0; n < len; n++)
      if (!key_set[n])
        send_beat(rc4_pkg::MODE_KEY, byte_t'($urandom), byte_t'(n), 1'($urandom));
  endtask

  task automatic send_message(int nbytes, int key_pct);
    if (rekey_pending) load_missing_keys();
    for (int b = 0; b < nbytes; b++) begin
      if ($urandom_range(0, 99) < key_pct)
        send_beat(rc4_pkg::MODE_KEY, byte_t'($urandom), byte_t'($urandom), 1'($urandom));
      send_beat(rc4_pkg::MODE_DATA, byte_t'($urandom), byte_t'($urandom), b == nbytes - 1);
    end
  endtask

  task automatic test_directed();
    write_key_length(0);
    send_beat(rc4_pkg::MODE_KEY, 8'hFF, 8'h00, 1'b1);
    send_beat(rc4_pkg::MODE_KEY, 8'h00, 8'hFF, 1'b0);
    send_beat(rc4_pkg::MODE_DATA, 8'h00, 8'h00, 1'b0);
    send_beat(rc4_pkg::MODE_DATA, 8'hFF, 8'hFF, 1'b0);
    // key change mid-message only shows up at the next schedule
    send_beat(rc4_pkg::MODE_KEY, 8'h00, 8'h00, 1'b0);
    send_beat(rc4_pkg::MODE_DATA, 8'hA5, 8'h00, 1'b1);
    send_beat(rc4_pkg::MODE_DATA, 8'h5A, 8'h00, 1'b1);
    write_key_length(2);
    send_beat(rc4_pkg::MODE_KEY, 8'hFF, 8'h01, 1'b0);
    send_beat(rc4_pkg::MODE_DATA, 8'hFF, 8'h00, 1'b0);
    send_beat(rc4_pkg::MODE_DATA, 8'h00, 8'hFF, 1'b1);
    wait_for_results();
  endtask

  task automatic test_key_length_extremes();
    int lens [8] = '{1, 256, 511, 257, 5, 255, 0, 16};
    foreach (lens[n]) begin
      write_key_length(lens[n]);
      send_message(3, 0);
      send_message(2, 10);
      // one message long enough for the byte index to wrap
      if (lens[n] == 511) send_message(300, 0);
    end
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    wait_for_results();
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    send_message(40, 0);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int r;
    int nbytes;
    int klen;
    while (items_sent < TOTAL_ITEMS) begin
      send_gaps = $urandom_range(0, 3) != 0;
      recv_gaps = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        case ($urandom_range(0, 7))
          0: klen = 0;
          1: klen = 1;
          2: klen = 256;
          3: klen = 511;
          default: klen = $urandom_range(1, 40);
        endcase
        write_key_length(klen);
      end else if (r < 8) begin
        wait_for_results();
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4))
          send_beat(rc4_pkg::MODE_KEY, byte_t'($urandom),
                    byte_t'($urandom_range(0, used_key_len() - 1)), 1'($urandom));
      r = $urandom_range(0, 99);
      if (r < 15) nbytes = 1;
      else if (r < 85) nbytes = $urandom_range(2, 10);
      else if (r < 98) nbytes = $urandom_range(11, 30);
      else nbytes = 60;
      send_message(nbytes, 8);
    end
    wait_for_results();
  endtask

  initial begin
    key_len = rc4_pkg::KEY_LEN_RST;
    rekey_pending = 1'b1;
    idx_i = '0;
    idx_j = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_key_length_extremes();
    test_output_backpressure();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && cipher_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!recv_gaps || $urandom_range(0, 99) < 70) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = pick_gap(1'b1);
      end
    end
  end

  always @(posedge clk) begin
    cipher_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected beat out_byte=%h keystream_byte=%h result_last=%b",
                 $time, out_byte, keystream_byte, result_last);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (out_byte !== want.cipher) begin
          $display("%0t: out_byte expected %h got %h", $time, want.cipher, out_byte);
          errors++;
        end
        if (keystream_byte !== want.stream) begin
          $display("%0t: keystream_byte expected %h got %h",
                   $time, want.stream, keystream_byte);
          errors++;
        end
        if (result_last !== want.last) begin
          $display("%0t: result_last expected %b got %b", $time, want.last, result_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
